@@ rtl/irpfd_pkg.sv @@
// Shared types, codes and helpers for the infrared pulse frame decoder.
`timescale 1ns / 1ps

package irpfd_pkg;

    localparam int DATA_BITS_DEF = 32;
    localparam int DUR_W         = 16;
    localparam int TOL_W         = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 16;
    localparam int WORD_W        = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MARK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_SPACE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_SPACE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_UNIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE   = 3'd5;

    // Reset values of the configuration registers
    localparam logic [TOL_W-1:0] TOLERANCE_RST    = 12'd300;
    localparam logic [DUR_W-1:0] LEADER_MARK_RST  = 16'd9000;
    localparam logic [DUR_W-1:0] DATA_SPACE_RST   = 16'd4500;
    localparam logic [DUR_W-1:0] REPEAT_SPACE_RST = 16'd2250;
    localparam logic [DUR_W-1:0] BIT_UNIT_RST     = 16'd560;
    localparam logic [DUR_W-1:0] ONE_SPACE_RST    = 16'd1680;

    // Input word kinds
    localparam logic OP_INTERVAL  = 1'b0;
    localparam logic OP_FRAME_END = 1'b1;

    // Frame status codes
    localparam logic [STATUS_W-1:0] STATUS_ERROR  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DATA   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REPEAT = 2'd2;

    typedef enum logic [2:0] {
        CLS_UNKNOWN   = 3'd0,
        CLS_LEADER    = 3'd1,
        CLS_DATA      = 3'd2,
        CLS_MAYBE_REP = 3'd3,
        CLS_REPEAT    = 3'd4,
        CLS_BAD       = 3'd5
    } frame_class_t;

    typedef struct packed {
        logic [TOL_W-1:0] tolerance;
        logic [DUR_W-1:0] leader_mark;
        logic [DUR_W-1:0] data_space;
        logic [DUR_W-1:0] repeat_space;
        logic [DUR_W-1:0] bit_unit;
        logic [DUR_W-1:0] one_space;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   code;
        logic [COUNT_W-1:0]  count;
    } result_t;

    // Duration within tolerance of a nominal: |d - nom| < tol
    function automatic logic near(input logic [DUR_W-1:0] d,
                                  input logic [DUR_W-1:0] nom,
                                  input logic [TOL_W-1:0] tol);
        logic [DUR_W-1:0] diff;
        diff = (d >= nom) ? (d - nom) : (nom - d);
        return diff < {{(DUR_W-TOL_W){1'b0}}, tol};
    endfunction

endpackage

@@ rtl/irpfd_decode.sv @@
// Next-state and result logic for one interval or frame-end word.
`timescale 1ns / 1ps

module irpfd_decode #(
    parameter int DATA_BITS = irpfd_pkg::DATA_BITS_DEF,
    parameter int IW        = 7
) (
    input  irpfd_pkg::cfg_t                  cfg,
    input  logic                             op,
    input  logic [irpfd_pkg::DUR_W-1:0]      dur,
    input  logic [IW-1:0]                    idx,
    input  irpfd_pkg::frame_class_t          cls,
    input  logic [DATA_BITS-1:0]             cw,
    input  logic [irpfd_pkg::COUNT_W-1:0]    rc,
    output logic [IW-1:0]                    idx_next,
    output irpfd_pkg::frame_class_t          cls_next,
    output logic [DATA_BITS-1:0]             cw_next,
    output logic [irpfd_pkg::COUNT_W-1:0]    rc_next,
    output irpfd_pkg::result_t               res
);
    import irpfd_pkg::*;

    localparam int FRAME_LEN = 2 * (DATA_BITS + 1);
    localparam int PW        = $clog2(DATA_BITS);

    logic m_l, m_d, m_r, m_b, m_o;
    logic z_l, z_d, z_r, z_b, z_o;
    logic [IW-1:0] pos_full;
    logic [PW-1:0] pos;

    // frame-end completion
    frame_class_t         c_lead;
    frame_class_t         c_end;
    logic                 clr_end;
    logic [IW-1:0]        idx2;
    logic [IW-1:0]        k_done;
    logic                 mark_rem;
    logic                 space_rem;
    logic                 data_ok;
    logic [DATA_BITS-1:0] cw_fill;
    logic [COUNT_W-1:0]   rc_base;
    logic [63:0]          cw_ext;

    assign m_l = near(dur, cfg.leader_mark, cfg.tolerance);
    assign m_d = near(dur, cfg.data_space, cfg.tolerance);
    assign m_r = near(dur, cfg.repeat_space, cfg.tolerance);
    assign m_b = near(dur, cfg.bit_unit, cfg.tolerance);
    assign m_o = near(dur, cfg.one_space, cfg.tolerance);

    // missing intervals decode as zero length
    assign z_l = near('0, cfg.leader_mark, cfg.tolerance);
    assign z_d = near('0, cfg.data_space, cfg.tolerance);
    assign z_r = near('0, cfg.repeat_space, cfg.tolerance);
    assign z_b = near('0, cfg.bit_unit, cfg.tolerance);
    assign z_o = near('0, cfg.one_space, cfg.tolerance);

    // bit position of a space: first data bit lands in the top bit
    assign pos_full = IW'(DATA_BITS - 1) - ((idx - IW'(3)) >> 1);
    assign pos      = pos_full[PW-1:0];

    // class after zero-filling leader intervals still missing
    always_comb
    begin
        c_lead  = cls;
        clr_end = 1'b0;
        if (idx == '0)
        begin
            c_lead = z_l ? CLS_LEADER : CLS_BAD;
        end
        if (idx < IW'(2))
        begin
            if (c_lead != CLS_LEADER)
            begin
                c_lead = CLS_BAD;
            end
            else if (z_d)
            begin
                c_lead  = CLS_DATA;
                clr_end = 1'b1;
            end
            else if (z_r)
            begin
                c_lead = CLS_MAYBE_REP;
            end
            else
            begin
                c_lead = CLS_BAD;
            end
        end
    end

    assign idx2      = (idx < IW'(2)) ? IW'(2) : idx;
    assign k_done    = (idx2 - IW'(2)) >> 1;
    assign mark_rem  = idx2 <= IW'(FRAME_LEN - 2);
    assign space_rem = idx2 <= IW'(FRAME_LEN - 1);
    assign data_ok   = (!mark_rem || z_b) && (!space_rem || z_o || z_b);

    always_comb
    begin
        c_end = c_lead;
        if (idx2 < IW'(FRAME_LEN))
        begin
            if (c_lead == CLS_MAYBE_REP)
            begin
                c_end = z_b ? CLS_REPEAT : CLS_BAD;
            end
            else if (c_lead == CLS_DATA && !data_ok)
            begin
                c_end = CLS_BAD;
            end
        end
    end

    // undecoded low bits take the zero-length space value
    always_comb
    begin
        cw_fill = cw;
        for (int p = 0; p < DATA_BITS; p++)
        begin
            if ((IW'(p) + k_done) < IW'(DATA_BITS))
            begin
                cw_fill[p] = z_o;
            end
        end
    end

    assign rc_base = clr_end ? '0 : rc;
    assign cw_ext  = 64'(cw_fill);

    always_comb
    begin
        idx_next = idx;
        cls_next = cls;
        cw_next  = cw;
        rc_next  = rc;
        res      = '0;
        if (op == OP_INTERVAL)
        begin
            if (idx < IW'(FRAME_LEN))
            begin
                idx_next = idx + IW'(1);
                if (idx == '0)
                begin
                    cls_next = m_l ? CLS_LEADER : CLS_BAD;
                end
                else if (idx == IW'(1))
                begin
                    if (cls != CLS_LEADER)
                    begin
                        cls_next = CLS_BAD;
                    end
                    else if (m_d)
                    begin
                        cls_next = CLS_DATA;
                        rc_next  = '0;
                    end
                    else if (m_r)
                    begin
                        cls_next = CLS_MAYBE_REP;
                    end
                    else
                    begin
                        cls_next = CLS_BAD;
                    end
                end
                else if (cls == CLS_MAYBE_REP)
                begin
                    cls_next = m_b ? CLS_REPEAT : CLS_BAD;
                end
                else if (cls == CLS_DATA)
                begin
                    if (!idx[0])
                    begin
                        if (!m_b)
                        begin
                            cls_next = CLS_BAD;
                        end
                    end
                    else
                    begin
                        for (int p = 0; p < DATA_BITS; p++)
                        begin
                            if (PW'(p) == pos)
                            begin
                                if (m_o)
                                begin
                                    cw_next[p] = 1'b1;
                                end
                                else if (m_b)
                                begin
                                    cw_next[p] = 1'b0;
                                end
                            end
                        end
                        if (!m_o && !m_b)
                        begin
                            cls_next = CLS_BAD;
                        end
                    end
                end
            end
        end
        else
        begin
            idx_next = '0;
            cls_next = CLS_UNKNOWN;
            rc_next  = rc_base;
            case (c_end)
                CLS_DATA:
                begin
                    cw_next    = cw_fill;
                    res.status = STATUS_DATA;
                    res.code   = cw_ext[WORD_W-1:0];
                end
                CLS_REPEAT:
                begin
                    rc_next    = rc_base + COUNT_W'(1);
                    res.status = STATUS_REPEAT;
                end
                default:
                begin
                    res.status = STATUS_ERROR;
                end
            endcase
            res.count = rc_next;
        end
    end

endmodule

@@ rtl/ir_pulse_frame_decoder_core.sv @@
// Top level of the infrared pulse frame decoder: handshakes, state and registers.
`timescale 1ns / 1ps

// Infrared remote frame decoder, NEC style.
// Input channel (in_valid/in_ready): each word is either a measured level
// duration in microseconds (opcode 0) or a frame end after an idle gap
// (opcode 1). Durations match a nominal when |d - nominal| < tolerance.
// Output channel (out_valid/out_ready): one word per frame end carrying the
// status (error, data, repeat), the four code bytes (zero unless data) and
// the repeat count since the last data leader. Intervals give no word.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// only write while the block is idle.
// Path: an accepted frame-end word goes through the input register, then
// is decoded into the output register, which drives the output channel.
// Throughput: one word per cycle; the decode of a word is a handful of
// comparators and a bit insert between the input and output registers.
// A stalled receiver holds only frame-end words; intervals keep flowing
// until a frame end meets a full output register.
// Reset: registers return to their nominal defaults, decoder state,
// code word and repeat count clear, both channels empty.

module ir_pulse_frame_decoder_core #(
    parameter int DATA_BITS = irpfd_pkg::DATA_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic [irpfd_pkg::DUR_W-1:0]       duration_us,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [irpfd_pkg::STATUS_W-1:0]    frame_status,
    output logic [7:0]                        address_byte,
    output logic [7:0]                        address_inverse,
    output logic [7:0]                        command_byte,
    output logic [7:0]                        command_inverse,
    output logic [irpfd_pkg::COUNT_W-1:0]     repeat_count,
    input  logic                              cfg_we,
    input  logic [irpfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [irpfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import irpfd_pkg::*;

    localparam int FRAME_LEN = 2 * (DATA_BITS + 1);
    localparam int IW        = $clog2(FRAME_LEN + 1);

    cfg_t cfg_reg;

    // input register
    logic             s1_valid_reg;
    logic             s1_op_reg;
    logic [DUR_W-1:0] s1_dur_reg;

    // decoder state
    logic [IW-1:0]        idx_reg;
    frame_class_t         cls_reg;
    logic [DATA_BITS-1:0] cw_reg;
    logic [COUNT_W-1:0]   rc_reg;

    logic [IW-1:0]        idx_next;
    frame_class_t         cls_next;
    logic [DATA_BITS-1:0] cw_next;
    logic [COUNT_W-1:0]   rc_next;
    result_t              res_next;

    // output register
    logic    out_valid_reg;
    result_t out_reg;

    logic out_free;
    logic s1_adv;

    assign out_free = !out_valid_reg || out_ready;
    // intervals never wait; a frame end needs room in the output register
    assign s1_adv   = s1_valid_reg && ((s1_op_reg == OP_INTERVAL) || out_free);
    assign in_ready = !s1_valid_reg || s1_adv;

    irpfd_decode #(
        .DATA_BITS (DATA_BITS),
        .IW        (IW)
    ) u_decode (
        .cfg      (cfg_reg),
        .op       (s1_op_reg),
        .dur      (s1_dur_reg),
        .idx      (idx_reg),
        .cls      (cls_reg),
        .cw       (cw_reg),
        .rc       (rc_reg),
        .idx_next (idx_next),
        .cls_next (cls_next),
        .cw_next  (cw_next),
        .rc_next  (rc_next),
        .res      (res_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tolerance    <= TOLERANCE_RST;
            cfg_reg.leader_mark  <= LEADER_MARK_RST;
            cfg_reg.data_space   <= DATA_SPACE_RST;
            cfg_reg.repeat_space <= REPEAT_SPACE_RST;
            cfg_reg.bit_unit     <= BIT_UNIT_RST;
            cfg_reg.one_space    <= ONE_SPACE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOLERANCE:    cfg_reg.tolerance    <= cfg_data[TOL_W-1:0];
                CFG_LEADER_MARK:  cfg_reg.leader_mark  <= cfg_data;
                CFG_DATA_SPACE:   cfg_reg.data_space   <= cfg_data;
                CFG_REPEAT_SPACE: cfg_reg.repeat_space <= cfg_data;
                CFG_BIT_UNIT:     cfg_reg.bit_unit     <= cfg_data;
                CFG_ONE_SPACE:    cfg_reg.one_space    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_op_reg  <= opcode;
            s1_dur_reg <= duration_us;
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cls_reg <= CLS_UNKNOWN;
            cw_reg  <= '0;
            rc_reg  <= '0;
        end
        else if (s1_adv)
        begin
            idx_reg <= idx_next;
            cls_reg <= cls_next;
            cw_reg  <= cw_next;
            rc_reg  <= rc_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && (s1_op_reg == OP_FRAME_END))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && (s1_op_reg == OP_FRAME_END))
        begin
            out_reg <= res_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_status    = out_reg.status;
    assign address_byte    = out_reg.code[31:24];
    assign address_inverse = out_reg.code[23:16];
    assign command_byte    = out_reg.code[15:8];
    assign command_inverse = out_reg.code[7:0];
    assign repeat_count    = out_reg.count;

endmodule
